FILE: src/tournament_tree_sort_unit_defines.svh
// assertion macros for the tournament tree sort unit
// no dependencies; included by the files that carry assertions
`ifndef TOURNAMENT_TREE_SORT_UNIT_DEFINES_SVH
`define TOURNAMENT_TREE_SORT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tts_pkg.sv
// shared constants for the tournament tree sort unit
// no dependencies; used by every module of the block
package tts_pkg;

	// default capacity and data width
	localparam int MAX_ITEMS_DEF  = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// derived defaults for the node memory and compare unit
	localparam int LEAF_W_DEF  = $clog2(MAX_ITEMS_DEF);
	localparam int NODES_DEF   = 2 * (2 ** LEAF_W_DEF) - 1;
	localparam int ENTRY_W_DEF = 1 + LEAF_W_DEF + DATA_WIDTH_DEF;

endpackage

FILE: src/tts_node_mem.sv
// node memory of the tournament tree: one write port, two registered read ports
// depends on tts_pkg for its default sizes
module tts_node_mem #(
	parameter int WIDTH = tts_pkg::ENTRY_W_DEF,
	parameter int DEPTH = tts_pkg::NODES_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
	input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
	output logic [WIDTH-1:0]         rd_a_data,
	output logic [WIDTH-1:0]         rd_b_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule

FILE: src/tts_match.sv
// shared match unit: picks the winner of two tree entries {valid, index, value}
// depends on tts_pkg for its default sizes
module tts_match #(
	parameter int DATA_W = tts_pkg::DATA_WIDTH_DEF,
	parameter int IDX_W  = tts_pkg::LEAF_W_DEF
) (
	input  logic [IDX_W+DATA_W:0] left,
	input  logic [IDX_W+DATA_W:0] right,
	output logic [IDX_W+DATA_W:0] win
);

	logic              l_valid;
	logic              r_valid;
	logic [DATA_W-1:0] l_value;
	logic [DATA_W-1:0] r_value;
	logic              left_wins;

	assign l_valid = left[IDX_W+DATA_W];
	assign r_valid = right[IDX_W+DATA_W];
	assign l_value = left[DATA_W-1:0];
	assign r_value = right[DATA_W-1:0];

	// empty entries lose, ties go left
	always_comb begin
		if (l_valid && r_valid) begin
			left_wins = $signed(l_value) <= $signed(r_value);
		end else begin
			left_wins = l_valid;
		end
		win = left_wins ? left : right;
	end

endmodule

FILE: src/tournament_tree_sort_unit.sv
// top level of the tournament tree sort unit: load sequencer, tree build and replay
// depends on tts_pkg, tts_node_mem, tts_match and tournament_tree_sort_unit_defines.svh
//
// values are loaded one per start transfer, while busy stays low, into the
// leaves of a tournament tree held in a node memory; the transfer with is_last set
// ends the load, and items beyond MAX_ITEMS are dropped but is_last still counts.
// busy then stays high until the whole set is out. the unit first marks the unused
// leaves empty, then builds the tree bottom up, and then gives the results one at a
// time: it presents the root winner and empties its leaf (but for the final one),
// then replays the path one tree level at a time with the single match unit, which
// reads one sibling from the node memory per level.
// each result sits on sorted_value, source_position and last_out for exactly one
// cycle, marked by done; the receiver cannot stall it, so it must take every done
// transfer. results come in ascending signed order, equal values lowest load
// position first, and last_out marks the final one of the set.
`include "tournament_tree_sort_unit_defines.svh"

module tournament_tree_sort_unit #(
	parameter int MAX_ITEMS  = tts_pkg::MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = tts_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [DATA_WIDTH-1:0]  value,
	input  logic                          is_last,
	output logic                          done,
	output logic signed [DATA_WIDTH-1:0]  sorted_value,
	output logic [$clog2(MAX_ITEMS)-1:0]  source_position,
	output logic                          last_out
);

	localparam int LW      = $clog2(MAX_ITEMS);     // leaf index width
	localparam int LEAVES  = 2 ** LW;
	localparam int AW      = LW + 1;                 // node address width
	localparam int NODES   = 2 * LEAVES - 1;
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int ENTRY_W = 1 + LW + DATA_WIDTH;    // {valid, index, value}

	localparam logic [AW-1:0]    LEAF_BASE  = AW'(LEAVES - 1);
	localparam logic [AW-1:0]    LAST_INNER = AW'(LEAVES - 2);
	localparam logic [AW-1:0]    LEAF_COUNT = AW'(LEAVES);
	localparam logic [CNT_W-1:0] CAPACITY   = CNT_W'(MAX_ITEMS);

	typedef enum logic [5:0] {
		IDLE     = 6'b000001,
		CLEAR    = 6'b000010,
		BUILD_RD = 6'b000100,
		BUILD_WR = 6'b001000,
		EMIT     = 6'b010000,
		REPLAY   = 6'b100000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   cnt_q;     // items loaded in the current set
	logic [CNT_W-1:0]   total_q;   // size of the set being sorted
	logic [CNT_W-1:0]   out_q;     // results already given
	logic [AW-1:0]      clr_q;     // leaf being marked empty
	logic [AW-1:0]      bn_q;      // inner node being built
	logic [AW-1:0]      node_q;    // node on the replay path
	logic [ENTRY_W-1:0] win_q;     // current root winner
	logic [ENTRY_W-1:0] carry_q;   // entry climbing the replay path

	logic               accept;
	logic               load_ok;
	logic [CNT_W-1:0]   cnt_next;
	logic               is_final;
	logic [AW-1:0]      leaf_w;
	logic [AW-1:0]      parent;
	logic [AW-1:0]      build_left;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [AW-1:0]      rd_a_addr;
	logic [AW-1:0]      rd_b_addr;
	logic [ENTRY_W-1:0] rd_a_data;
	logic [ENTRY_W-1:0] rd_b_data;

	logic [ENTRY_W-1:0] m_left;
	logic [ENTRY_W-1:0] m_right;
	logic [ENTRY_W-1:0] m_win;

	// the other child of the same parent
	function automatic logic [AW-1:0] sibling(input logic [AW-1:0] n);
		return n[0] ? AW'(n + AW'(1)) : AW'(n - AW'(1));
	endfunction

	assign busy     = (state_q != IDLE);
	assign accept   = start && !busy;
	assign load_ok  = (cnt_q < CAPACITY);
	assign cnt_next = load_ok ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	assign is_final = (CNT_W'(out_q + 1'b1) == total_q);

	assign leaf_w     = AW'(LEAF_BASE + AW'(win_q[DATA_WIDTH +: LW]));
	assign parent     = AW'((node_q - AW'(1)) >> 1);
	assign build_left = {bn_q[AW-2:0], 1'b1};

	// result value and position come straight from the root winner register
	assign done            = (state_q == EMIT);
	assign sorted_value    = win_q[DATA_WIDTH-1:0];
	assign source_position = win_q[DATA_WIDTH +: LW];
	assign last_out        = done && is_final;

	tts_node_mem #(
		.WIDTH (ENTRY_W),
		.DEPTH (NODES)
	) u_node_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	tts_match #(
		.DATA_W (DATA_WIDTH),
		.IDX_W  (LW)
	) u_match (
		.left  (m_left),
		.right (m_right),
		.win   (m_win)
	);

	// memory port and match unit steering
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = AW'(LEAF_BASE + AW'(cnt_q));
		wr_data   = {1'b1, LW'(cnt_q), value};
		rd_a_addr = build_left;
		rd_b_addr = AW'(build_left + AW'(1));
		m_left    = rd_a_data;
		m_right   = rd_b_data;
		unique case (state_q)
			IDLE: begin
				// new leaf for each stored item
				wr_en = accept && load_ok;
			end
			CLEAR: begin
				// unused leaves always lose
				wr_en   = 1'b1;
				wr_addr = AW'(LEAF_BASE + clr_q);
				wr_data = '0;
			end
			BUILD_RD: begin
				// both children read at once
			end
			BUILD_WR: begin
				wr_en   = 1'b1;
				wr_addr = bn_q;
				wr_data = m_win;
			end
			EMIT: begin
				// empty the winning leaf, unless it is the final result, and fetch its sibling
				wr_en     = !is_final;
				wr_addr   = leaf_w;
				wr_data   = '0;
				rd_b_addr = sibling(leaf_w);
			end
			REPLAY: begin
				// path entry on its own side, left child has odd address
				m_left    = node_q[0] ? carry_q : rd_b_data;
				m_right   = node_q[0] ? rd_b_data : carry_q;
				wr_en     = 1'b1;
				wr_addr   = parent;
				wr_data   = m_win;
				rd_b_addr = sibling(parent);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			total_q <= '0;
			out_q   <= '0;
			clr_q   <= '0;
			bn_q    <= '0;
			node_q  <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						cnt_q <= cnt_next;
						if (is_last) begin
							// sort starts, next transfer opens a new set
							cnt_q   <= '0;
							total_q <= cnt_next;
							clr_q   <= AW'(cnt_next);
							bn_q    <= LAST_INNER;
							state_q <= (AW'(cnt_next) == LEAF_COUNT) ? BUILD_RD : CLEAR;
						end
					end
				end
				CLEAR: begin
					if (clr_q == LEAF_BASE) begin
						state_q <= BUILD_RD;
					end else begin
						clr_q <= AW'(clr_q + AW'(1));
					end
				end
				BUILD_RD: begin
					state_q <= BUILD_WR;
				end
				BUILD_WR: begin
					if (bn_q == '0) begin
						out_q   <= '0;
						state_q <= EMIT;
					end else begin
						bn_q    <= AW'(bn_q - AW'(1));
						state_q <= BUILD_RD;
					end
				end
				EMIT: begin
					if (is_final) begin
						state_q <= IDLE;
					end else begin
						out_q   <= CNT_W'(out_q + 1'b1);
						node_q  <= leaf_w;
						state_q <= REPLAY;
					end
				end
				REPLAY: begin
					if (parent == '0) begin
						state_q <= EMIT;
					end else begin
						node_q <= parent;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// winner and path entries
	always_ff @(posedge clk) begin
		if ((state_q == BUILD_WR && bn_q == '0) || (state_q == REPLAY && parent == '0)) begin
			win_q <= m_win;
		end
		if (state_q == EMIT) begin
			carry_q <= '0;
		end else if (state_q == REPLAY) begin
			carry_q <= m_win;
		end
	end

	`TTS_ASSERT_IMPL(a_emit_has_winner, clk, arst_n, state_q == EMIT, win_q[ENTRY_W-1], "root winner empty while emitting")
	`TTS_ASSERT_IMPL(a_emit_in_range, clk, arst_n, state_q == EMIT, out_q < total_q, "more results than loaded items")
	`TTS_ASSERT_IMPL(a_replay_below_root, clk, arst_n, state_q == REPLAY, node_q != '0, "replay path reached past the root")
	`TTS_ASSERT_NEXT(a_last_starts_sort, clk, arst_n, accept && is_last, busy, "sort did not start after last item")
	`TTS_ASSERT_NEXT(a_final_frees_unit, clk, arst_n, done && last_out, !busy, "unit still busy after final result")

endmodule

FILE: verif/tournament_tree_sort_unit_tb.sv
// self-checking testbench for the tournament tree sort unit: loads signed sets,
// predicts the stable ascending order and checks every done transfer against it
// depends on tts_pkg and the tournament_tree_sort_unit rtl
`timescale 1ns / 1ps

module tournament_tree_sort_unit_tb;

	localparam int SET_CAP = tts_pkg::MAX_ITEMS_DEF;
	localparam int DW      = tts_pkg::DATA_WIDTH_DEF;
	localparam int PW      = tts_pkg::LEAF_W_DEF;

	// generous bound: every set at its slowest plus long sender gaps
	localparam int CYCLE_LIMIT  = 200000;
	// per-phase budget of small-set items in the random part
	localparam int PHASE_ITEMS  = 12;
	// quiet cycles after the last result
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_MAX   = 10;

	localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

	// one element of a sorted run as it should leave the block
	typedef struct {
		logic signed [DW-1:0] val;
		logic [PW-1:0]        pos;
		logic                 last;
	} sorted_entry_t;

	// holds the set being loaded and the sorted run still owed by the block
	class sort_scoreboard;
		logic signed [DW-1:0] held_vals[$];
		sorted_entry_t        owed_q[$];
		int                   mismatches;
		int                   results_seen;
		int                   sets_sorted;
		int                   dropped;

		function new();
			mismatches   = 0;
			results_seen = 0;
			sets_sorted  = 0;
			dropped      = 0;
		endfunction

		// an accepted load; the is_last transfer turns the held set into a sorted run
		function void note_load(logic signed [DW-1:0] v, logic last);
			sorted_entry_t work[$];
			sorted_entry_t e;
			int best;
			int k;
			if (held_vals.size() < SET_CAP) begin
				held_vals.push_back(v);
			end else begin
				dropped++;
			end
			if (!last) begin
				return;
			end
			foreach (held_vals[i]) begin
				e.val  = held_vals[i];
				e.pos  = PW'(i);
				e.last = 1'b0;
				work.push_back(e);
			end
			// strict less keeps the lowest load position first among equal values
			while (work.size() > 0) begin
				best = 0;
				for (k = 1; k < work.size(); k++) begin
					if (work[k].val < work[best].val) begin
						best = k;
					end
				end
				e = work[best];
				work.delete(best);
				e.last = (work.size() == 0);
				owed_q.push_back(e);
			end
			held_vals.delete();
			sets_sorted++;
		endfunction

		// a done transfer, compared with the oldest owed element
		function void check_result(logic signed [DW-1:0] v, logic [PW-1:0] pos, logic last);
			sorted_entry_t e;
			results_seen++;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("[%0t] unexpected result: value %0d pos %0d last %0b",
						$realtime, v, pos, last);
				end
				return;
			end
			e = owed_q.pop_front();
			if (v !== e.val || pos !== e.pos || last !== e.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display({"[%0t] mismatch: expected value %0d pos %0d last %0b,",
						" got value %0d pos %0d last %0b"},
						$realtime, e.val, e.pos, e.last, v, pos, last);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [DW-1:0] value;
	logic                 is_last;
	logic                 done;
	logic signed [DW-1:0] sorted_value;
	logic [PW-1:0]        source_position;
	logic                 last_out;

	sort_scoreboard board;
	int             send_idle_pct;
	int             items_sent;
	int             cycle_count;

	tournament_tree_sort_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.is_last         (is_last),
		.done            (done),
		.sorted_value    (sorted_value),
		.source_position (source_position),
		.last_out        (last_out)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sample both sides at the rising edge; a load is noted before any result
	// of the same edge, though the block is busy whenever a set is draining
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note_load(value, is_last);
			end
			if (done) begin
				board.check_result(sorted_value, source_position, last_out);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, board.owed_q.size());
			$display("tournament_tree_sort_unit_tb failed");
			$finish;
		end
	end

	// mix of full-range values, extremes and a narrow band that forces ties
	function automatic logic signed [DW-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2, 3: return int'($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// one load transfer; entered and left just after a falling edge
	task automatic transfer_item(input logic signed [DW-1:0] v, input logic last);
		// random sender gaps, value toggles as noise while start is low
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			value <= $urandom;
			is_last <= 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		start   <= 1'b1;
		value   <= v;
		is_last <= last;
		// hold until the block takes it; busy covers the whole sort phase
		do begin
			@(posedge clk);
		end while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	// a set of random values, is_last on the final one
	task automatic load_random_set(input int size);
		for (int k = 0; k < size; k++) begin
			transfer_item(pick_value(), k == size - 1);
		end
	endtask

	initial begin
		int phase_items;
		int size;
		board = new();
		items_sent  = 0;
		cycle_count = 0;
		send_idle_pct = 31;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		value   <= '0;
		is_last <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: single element set
		transfer_item(0, 1'b1);
		// two extremes loaded in descending order
		transfer_item(VAL_MAX, 1'b0);
		transfer_item(VAL_MIN, 1'b1);
		// equal values spread over the set, lowest position must win
		transfer_item(5, 1'b0);
		transfer_item(5, 1'b0);
		transfer_item(-1, 1'b0);
		transfer_item(5, 1'b1);
		// duplicated extremes around zero and minus one
		transfer_item(VAL_MAX, 1'b0);
		transfer_item(VAL_MIN, 1'b0);
		transfer_item(VAL_MAX, 1'b0);
		transfer_item(VAL_MIN, 1'b0);
		transfer_item(0, 1'b0);
		transfer_item(-1, 1'b1);
		// all equal
		transfer_item(-7, 1'b0);
		transfer_item(-7, 1'b0);
		transfer_item(-7, 1'b1);
		// already ascending, non power of two size
		transfer_item(-3, 1'b0);
		transfer_item(1, 1'b0);
		transfer_item(2, 1'b0);
		transfer_item(VAL_MAX - 1, 1'b0);
		transfer_item(VAL_MAX, 1'b1);

		// random: three sender idling profiles
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: send_idle_pct = 31;
				1: send_idle_pct = 65;
				default: send_idle_pct = 0;
			endcase
			// last phase opens with a set that overruns the store, is_last on a dropped load
			if (phase == 2) begin
				load_random_set($urandom_range(SET_CAP + 1, SET_CAP + 3));
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				size = $urandom_range(1, 9);
				load_random_set(size);
				phase_items += size;
			end
		end
		start <= 1'b0;

		// drain whatever is still owed, then let the block settle
		while (board.owed_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d loads in %0d sets, %0d results checked, %0d loads dropped past capacity",
			items_sent, board.sets_sorted, board.results_seen, board.dropped);
		$display("%0d mismatches, %0d results never seen", board.mismatches,
			board.owed_q.size());
		if (board.mismatches == 0 && board.owed_q.size() == 0) begin
			$display("tournament_tree_sort_unit_tb passed");
		end else begin
			$display("tournament_tree_sort_unit_tb failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/tts_pkg.sv
src/tts_node_mem.sv
src/tts_match.sv
src/tournament_tree_sort_unit.sv
verif/tournament_tree_sort_unit_tb.sv
